[sv/ple_pkg.sv]
// Shared types, field widths and codes of the positional list engine.
package ple_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int OP_W  = 2;
	localparam int POS_W = 5;
	localparam int VAL_W = 32;
	localparam int ST_W  = 2;
	localparam int IDX_W = 4;
	localparam int LEN_W = 5;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 2'd1;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LOAD,
		CMD_START,
		CMD_TAKE,
		CMD_UP,
		CMD_DN,
		CMD_INS_FIN,
		CMD_DEL_FIN,
		CMD_LIST_EMIT,
		CMD_ERR_EMIT
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHECK,
		S_TAKE,
		S_UP,
		S_DN,
		S_INS_FIN,
		S_DEL_FIN,
		S_LIST,
		S_ERR
	} state_t;

	typedef struct packed {
		status_t chk;
		logic    op_ins;
		logic    op_del;
		logic    walk_done;
		logic    list_last;
		logic    out_free;
	} dp_stat_t;

endpackage

[sv/ple_req_if.sv]
// Request channel: one word carries an operation, a position and a value.
interface ple_req_if import ple_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [OP_W-1:0]         operation;
	logic [POS_W-1:0]        position;
	logic signed [VAL_W-1:0] value;

	modport source(output valid, output operation, output position, output value,
		input ready);
	modport sink(input valid, input operation, input position, input value,
		output ready);
endinterface

[sv/ple_rsp_if.sv]
// Response channel: one word per emitted, inserted or removed element, or per error or empty list.
interface ple_rsp_if import ple_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [ST_W-1:0]         status;
	logic [IDX_W-1:0]        element_index;
	logic signed [VAL_W-1:0] element_value;
	logic [LEN_W-1:0]        length;
	logic                    last;

	modport source(output valid, output status, output element_index,
		output element_value, output length, output last, input ready);
	modport sink(input valid, input status, input element_index,
		input element_value, input length, input last, output ready);
endinterface

[sv/ple_ctl.sv]
// Controller state machine of the positional list engine.
module ple_ctl import ple_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     accept,
	input  dp_stat_t stat,
	output cmd_t     cmd,
	output logic     idle
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = CMD_NONE;
		idle    = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				idle = 1'b1;
				if (accept) begin
					cmd     = CMD_LOAD;
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd = CMD_START;
				priority if (stat.chk != ST_OK) begin
					state_d = S_ERR;
				end else if (stat.op_ins) begin
					state_d = S_UP;
				end else if (stat.op_del) begin
					state_d = S_TAKE;
				end else begin
					state_d = S_LIST;
				end
			end
			S_TAKE: begin
				cmd     = CMD_TAKE;
				state_d = S_DN;
			end
			S_UP: begin
				cmd = CMD_UP;
				if (stat.walk_done) begin
					state_d = S_INS_FIN;
				end
			end
			S_DN: begin
				cmd = CMD_DN;
				if (stat.walk_done) begin
					state_d = S_DEL_FIN;
				end
			end
			S_INS_FIN: begin
				if (stat.out_free) begin
					cmd     = CMD_INS_FIN;
					state_d = S_IDLE;
				end
			end
			S_DEL_FIN: begin
				if (stat.out_free) begin
					cmd     = CMD_DEL_FIN;
					state_d = S_IDLE;
				end
			end
			S_LIST: begin
				if (stat.out_free) begin
					cmd = CMD_LIST_EMIT;
					if (stat.list_last) begin
						state_d = S_IDLE;
					end
				end
			end
			S_ERR: begin
				if (stat.out_free) begin
					cmd     = CMD_ERR_EMIT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

[sv/ple_dp.sv]
// Datapath: element memory, count, walk cursor and the response register.
module ple_dp import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cmd_t                    cmd,
	input  logic [OP_W-1:0]         operation,
	input  logic [POS_W-1:0]        position,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    rsp_ready,
	output logic                    rsp_valid,
	output status_t                 rsp_status,
	output logic [IDX_W-1:0]        rsp_index,
	output logic signed [VAL_W-1:0] rsp_value,
	output logic [LEN_W-1:0]        rsp_length,
	output logic                    rsp_last,
	output dp_stat_t                stat
);

	localparam int CNT_W  = $clog2(CAPACITY + 1);
	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CMP_W  = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic signed [VAL_W-1:0] mem [CAPACITY];
	logic signed [VAL_W-1:0] rd_data_q;

	logic [OP_W-1:0]         op_q;
	logic [POS_W-1:0]        pos_q;
	logic signed [VAL_W-1:0] val_q;
	logic [CNT_W-1:0]        count_q;
	logic [CNT_W-1:0]        cur_q;
	logic                    pend_q;
	logic [ADDR_W-1:0]       wa_q;

	logic [CNT_W-1:0]        count_d;
	logic [CNT_W-1:0]        cur_d;
	logic                    pend_d;
	logic [ADDR_W-1:0]       wa_d;
	logic [CNT_W-1:0]        cur_m1;
	logic [CNT_W-1:0]        cur_p1;
	logic [CMP_W-1:0]        pos_c;
	logic [CMP_W-1:0]        count_c;
	logic [CMP_W-1:0]        cur_c;
	logic [CMP_W-1:0]        count_d_c;

	logic                    wr_en;
	logic [ADDR_W-1:0]       wr_addr;
	logic signed [VAL_W-1:0] wr_data;
	logic                    rd_en;
	logic [ADDR_W-1:0]       rd_addr;

	logic                    out_ld;
	status_t                 out_status;
	logic [IDX_W-1:0]        out_index;
	logic signed [VAL_W-1:0] out_value;
	logic                    out_last;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic [IDX_W-1:0]        out_index_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic [LEN_W-1:0]        out_length_q;
	logic                    out_last_q;

	status_t                 chk;
	logic                    op_ins;
	logic                    op_del;
	logic                    list_last;

	assign pos_c     = CMP_W'(pos_q);
	assign count_c   = CMP_W'(count_q);
	assign cur_c     = CMP_W'(cur_q);
	assign count_d_c = CMP_W'(count_d);
	assign cur_m1    = cur_q - 1'b1;
	assign cur_p1    = cur_q + 1'b1;

	assign op_ins    = (op_q == OP_INSERT);
	assign op_del    = (op_q == OP_DELETE);
	assign list_last = (CMP_W'(cur_p1) == count_c);

	// Range check first, then capacity; operation code 3 lists like code 2.
	always_comb begin
		chk = ST_OK;
		priority if (op_ins) begin
			if (pos_c > count_c) begin
				chk = ST_RANGE;
			end else if (count_c >= CMP_W'(CAPACITY)) begin
				chk = ST_FULL;
			end
		end else if (op_del) begin
			if (pos_c >= count_c) begin
				chk = ST_RANGE;
			end
		end else begin
			if (count_q == '0) begin
				chk = ST_EMPTY;
			end
		end
	end

	always_comb begin
		count_d    = count_q;
		cur_d      = cur_q;
		pend_d     = 1'b0;
		wa_d       = wa_q;
		wr_en      = 1'b0;
		wr_addr    = wa_q;
		wr_data    = rd_data_q;
		rd_en      = 1'b0;
		rd_addr    = cur_q[ADDR_W-1:0];
		out_ld     = 1'b0;
		out_status = ST_OK;
		out_index  = '0;
		out_value  = '0;
		out_last   = 1'b1;
		unique case (cmd)
			CMD_NONE, CMD_LOAD: begin
			end
			CMD_START: begin
				rd_en   = 1'b1;
				rd_addr = op_del ? pos_c[ADDR_W-1:0] : '0;
				cur_d   = op_ins ? count_q : '0;
			end
			CMD_TAKE: begin
				cur_d = CNT_W'(pos_c + 1'b1);
			end
			CMD_UP: begin
				// Move entries up one slot, highest first; the write follows in the cycle after the read.
				wr_en = pend_q;
				if (cur_c > pos_c) begin
					rd_en   = 1'b1;
					rd_addr = cur_m1[ADDR_W-1:0];
					wa_d    = cur_q[ADDR_W-1:0];
					pend_d  = 1'b1;
					cur_d   = cur_m1;
				end
			end
			CMD_DN: begin
				// Move entries down one slot, lowest first.
				wr_en = pend_q;
				if (cur_c < count_c) begin
					rd_en   = 1'b1;
					rd_addr = cur_q[ADDR_W-1:0];
					wa_d    = cur_m1[ADDR_W-1:0];
					pend_d  = 1'b1;
					cur_d   = cur_p1;
				end
			end
			CMD_INS_FIN: begin
				wr_en     = 1'b1;
				wr_addr   = pos_c[ADDR_W-1:0];
				wr_data   = val_q;
				count_d   = count_q + 1'b1;
				out_ld    = 1'b1;
				out_index = pos_c[IDX_W-1:0];
				out_value = val_q;
			end
			CMD_DEL_FIN: begin
				count_d   = count_q - 1'b1;
				out_ld    = 1'b1;
				out_index = pos_c[IDX_W-1:0];
				out_value = val_q;
			end
			CMD_LIST_EMIT: begin
				out_ld    = 1'b1;
				out_index = cur_c[IDX_W-1:0];
				out_value = rd_data_q;
				out_last  = list_last;
				if (!list_last) begin
					rd_en   = 1'b1;
					rd_addr = cur_p1[ADDR_W-1:0];
					cur_d   = cur_p1;
				end
			end
			CMD_ERR_EMIT: begin
				out_ld     = 1'b1;
				out_status = chk;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd == CMD_LOAD) begin
			op_q  <= operation;
			pos_q <= position;
			val_q <= value;
		end else if (cmd == CMD_TAKE) begin
			val_q <= rd_data_q;
		end
		if (out_ld) begin
			out_status_q <= out_status;
			out_index_q  <= out_index;
			out_value_q  <= out_value;
			out_length_q <= count_d_c[LEN_W-1:0];
			out_last_q   <= out_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			cur_q       <= '0;
			pend_q      <= 1'b0;
			wa_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			cur_q   <= cur_d;
			pend_q  <= pend_d;
			wa_q    <= wa_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid  = out_valid_q;
	assign rsp_status = out_status_q;
	assign rsp_index  = out_index_q;
	assign rsp_value  = out_value_q;
	assign rsp_length = out_length_q;
	assign rsp_last   = out_last_q;

	assign stat.chk       = chk;
	assign stat.op_ins    = op_ins;
	assign stat.op_del    = op_del;
	assign stat.walk_done = !pend_q && (op_ins ? !(cur_c > pos_c) : !(cur_c < count_c));
	assign stat.list_last = list_last;
	assign stat.out_free  = !out_valid_q || rsp_ready;

endmodule

[sv/positional_list_engine_top.sv]
// Top level of the positional list engine: a bounded ordered list of signed values.
//
// The engine holds up to CAPACITY signed 32-bit values in a single-port-write,
// single-port-read memory with registered read data. A request word carries an
// operation: insert places value at position (0 up to the current length) and
// moves later elements up; delete removes the element at position (below the
// length), moves later elements down and returns it; list (codes 2 and 3) sends
// every element in order. Insert and delete give one response word; list gives
// one per element with last set on the final one, or a single list-empty word
// when nothing is held. A bad position, or an insert into a full list, gives one
// word with the error status, zero index and value, last set, and changes
// nothing; the range check wins over the full check. Every word reports the
// length after the operation. One request is worked at a time: request.ready is
// high only while the engine is idle, but it rises again while the last
// response word still waits in the output register. The walk moves one element
// per cycle, limited by the memory's one read and one write port; list sends
// one word per cycle while the response side takes them, and stalls when it
// does not. The memory needs no clearing after reset, since only entries below
// the length are ever used.
module positional_list_engine_top import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic        clk,
	input logic        arst_n,
	ple_req_if.sink    request,
	ple_rsp_if.source  response
);

	cmd_t     cmd;
	dp_stat_t stat;
	logic     idle;
	logic     accept;
	status_t  rsp_status;

	// Take a word only when the controller is idle.
	assign request.ready = idle;
	assign accept        = request.valid && idle;

	ple_ctl u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.stat   (stat),
		.cmd    (cmd),
		.idle   (idle)
	);

	ple_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.operation  (request.operation),
		.position   (request.position),
		.value      (request.value),
		.rsp_ready  (response.ready),
		.rsp_valid  (response.valid),
		.rsp_status (rsp_status),
		.rsp_index  (response.element_index),
		.rsp_value  (response.element_value),
		.rsp_length (response.length),
		.rsp_last   (response.last),
		.stat       (stat)
	);

	assign response.status = rsp_status;

	// A request is worked alone: no second word right after one is taken.
	a_single_word: assert property (@(posedge clk) disable iff (!arst_n)
		(request.valid && request.ready) |=> !request.ready)
		else $error("request taken while previous one still in progress");

	// Never load the response register over a word that is still held.
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_INS_FIN || cmd == CMD_DEL_FIN || cmd == CMD_LIST_EMIT ||
		 cmd == CMD_ERR_EMIT) |-> stat.out_free)
		else $error("response register overwritten");

	// Error and empty words always close their request.
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(response.valid && rsp_status != ST_OK) |-> response.last)
		else $error("status word without last");

endmodule
